/* hdl/set_assoc_cache_tag_store_assert.svh */
// Assertion helpers shared by the tag store RTL.
`ifndef SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_STORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SACTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define SACTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sacts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sacts_pkg;

  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 8'd3;

  // Replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] RST_WAYS     = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_SET_BITS = 4'd8;
  localparam logic [CFG_DATA_W-1:0] RST_OFFSET   = 4'd6;

  // One finished access, as seen by the statistics counters
  typedef struct packed {
    logic upd;
    logic hit;
    logic is_write;
  } stat_evt_t;

endpackage

`default_nettype wire

/* hdl/sacts_stats.sv */
`timescale 1ns / 1ps
`default_nettype none

module sacts_stats (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire sacts_pkg::stat_evt_t    evt,
  output logic [sacts_pkg::CNT_W-1:0]  hit_total,
  output logic [sacts_pkg::CNT_W-1:0]  miss_total,
  output logic [sacts_pkg::CNT_W-1:0]  read_total,
  output logic [sacts_pkg::CNT_W-1:0]  write_total
);

  logic [sacts_pkg::CNT_W-1:0] hit_r, miss_r, read_r, write_r;

  // Advance the running totals once per finished access
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= '0;
      miss_r  <= '0;
      read_r  <= '0;
      write_r <= '0;
    end else if (evt.upd) begin
      if (evt.hit) begin
        hit_r <= hit_r + 1'b1;
      end else begin
        miss_r <= miss_r + 1'b1;
        read_r <= read_r + 1'b1;
      end
      if (evt.is_write) begin
        write_r <= write_r + 1'b1;
      end
    end
  end

  assign hit_total   = hit_r;
  assign miss_total  = miss_r;
  assign read_total  = read_r;
  assign write_total = write_r;

endmodule

`default_nettype wire

/* hdl/set_assoc_cache_tag_store.sv */
// Tag store of a set-associative, write-through, write-allocate cache with FIFO or LRU
// replacement. Each access beat (read or write of a byte address) returns one result beat:
// hit, memory_read on a miss, memory_write on every write, and the running hit, miss,
// read and write totals after the access. One set is held per memory row; an access reads
// the row, walks its ways one per cycle through a single tag comparator, then writes the
// updated row back. A new access is accepted only once the last one has been written back;
// the ways in use are clamped to 1..MAX_WAYS, and the write-back waits for the result
// register to be free. After reset a clearing pass writes MAX_SETS rows before the first
// access is accepted; configuration writes are taken at any time and must only be issued
// while no access is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_tag_store_assert.svh"

module set_assoc_cache_tag_store #(
  parameter int MAX_SETS     = 256,
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 48
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write channel
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [sacts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sacts_pkg::CFG_DATA_W-1:0]    cfg_data,
  // access channel
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_command,
  input  wire  [ADDRESS_BITS-1:0]             in_address,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_hit,
  output logic                                out_memory_read,
  output logic                                out_memory_write,
  output logic [sacts_pkg::CNT_W-1:0]         out_hit_total,
  output logic [sacts_pkg::CNT_W-1:0]         out_miss_total,
  output logic [sacts_pkg::CNT_W-1:0]         out_read_total,
  output logic [sacts_pkg::CNT_W-1:0]         out_write_total
);

  localparam int SBITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W    = WAY_W;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int OLD_W     = $clog2(MAX_WAYS + 1);

  localparam logic [SET_AW-1:0] LAST_ROW = SET_AW'(MAX_SETS - 1);
  localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(MAX_WAYS - 1);
  localparam logic [OLD_W-1:0]  OLD_NONE = OLD_W'(MAX_WAYS);

  typedef struct packed {
    logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] tag;
    logic [MAX_WAYS-1:0]                   valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0]       rank;
  } row_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_READ,
    S_SCAN,
    S_WRITE
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                             policy_r;
  logic [sacts_pkg::CFG_DATA_W-1:0] ways_cfg_r;
  logic [sacts_pkg::CFG_DATA_W-1:0] sbits_cfg_r;
  logic [sacts_pkg::CFG_DATA_W-1:0] offset_r;

  assign cfg_ready = 1'b1;

  // Take a configuration beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= sacts_pkg::POLICY_FIFO;
      ways_cfg_r  <= sacts_pkg::RST_WAYS;
      sbits_cfg_r <= sacts_pkg::RST_SET_BITS;
      offset_r    <= sacts_pkg::RST_OFFSET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacts_pkg::CFG_POLICY:   policy_r    <= cfg_data[0];
        sacts_pkg::CFG_WAYS:     ways_cfg_r  <= cfg_data;
        sacts_pkg::CFG_SET_BITS: sbits_cfg_r <= cfg_data;
        sacts_pkg::CFG_OFFSET:   offset_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp associativity and set-index width to what the store holds
  logic [WCNT_W-1:0] ways_eff;
  logic [4:0]        sbits_eff;

  always_comb begin
    if (ways_cfg_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (6'(ways_cfg_r) > 6'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_cfg_r);
    end
    if (5'(sbits_cfg_r) > 5'(SBITS_MAX)) begin
      sbits_eff = 5'(SBITS_MAX);
    end else begin
      sbits_eff = 5'(sbits_cfg_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and scan registers
  // ---------------------------------------------------------------------------
  state_t                  state_r;
  logic [SET_AW-1:0]       clr_cnt_r;
  logic                    cmd_r;
  logic [ADDRESS_BITS-1:0] addr_r;
  logic [SET_AW-1:0]       set_r;
  logic [ADDRESS_BITS-1:0] tag_r;
  logic [WCNT_W-1:0]       ways_eff_r;
  logic [WAY_W-1:0]        way_r;
  logic                    found_r;
  logic [WAY_W-1:0]        found_way_r;
  logic                    free_r;
  logic [WAY_W-1:0]        free_way_r;
  logic [WAY_W-1:0]        vict_way_r;
  logic [RANK_W-1:0]       vict_rank_r;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic                    out_mem_write_r;
  row_t                    row_rd_r;

  // Split the address into set index and tag
  logic [ADDRESS_BITS-1:0] addr_shifted;
  logic [SET_AW-1:0]       set_c;
  logic [ADDRESS_BITS-1:0] tag_c;

  always_comb begin
    addr_shifted = addr_r >> offset_r;
    tag_c        = addr_r >> (6'(offset_r) + 6'(sbits_eff));
    for (int i = 0; i < SET_AW; i++) begin
      set_c[i] = addr_shifted[i] & (5'(i) < sbits_eff);
    end
  end

  // Shared tag comparator on the way under scan
  logic [ADDRESS_BITS-1:0] cur_tag;
  logic                    cur_valid;
  logic [RANK_W-1:0]       cur_rank;
  logic                    cur_match;
  logic                    scan_last;

  assign cur_tag   = row_rd_r.tag[way_r];
  assign cur_valid = row_rd_r.valid[way_r];
  assign cur_rank  = row_rd_r.rank[way_r];
  assign cur_match = cur_valid && (cur_tag == tag_r);
  assign scan_last = (WCNT_W'(way_r) + WCNT_W'(1)) == ways_eff_r;

  // Finish the access once the result register is free
  sacts_pkg::stat_evt_t evt;
  logic                 wr_go;

  assign wr_go        = (state_r == S_WRITE) && (!out_valid_r || out_ready);
  assign evt.upd      = wr_go;
  assign evt.hit      = found_r;
  assign evt.is_write = cmd_r;

  // Pick the way to promote and the rank that bounds aging
  logic [WAY_W-1:0] pick_way;
  logic [OLD_W-1:0] old_rank;
  logic             do_promote;
  row_t             new_row;

  always_comb begin
    if (found_r) begin
      pick_way = found_way_r;
      old_rank = OLD_W'(row_rd_r.rank[found_way_r]);
    end else if (free_r) begin
      pick_way = free_way_r;
      old_rank = OLD_NONE;
    end else begin
      pick_way = vict_way_r;
      old_rank = OLD_W'(vict_rank_r);
    end
    do_promote = !found_r || (policy_r == sacts_pkg::POLICY_LRU);

    // Age younger lines and refresh the picked line, one lane per way
    new_row = row_rd_r;
    if (do_promote) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (WCNT_W'(w) < ways_eff_r) begin
          if (WAY_W'(w) == pick_way) begin
            new_row.rank[w] = '0;
            if (!found_r) begin
              new_row.tag[w]   = tag_r;
              new_row.valid[w] = 1'b1;
            end
          end else if (row_rd_r.valid[w] && (OLD_W'(row_rd_r.rank[w]) < old_rank) &&
                       (row_rd_r.rank[w] < MAX_RANK)) begin
            new_row.rank[w] = row_rd_r.rank[w] + 1'b1;
          end
        end
      end
    end
  end

  // Sequence one access: prepare, read the set, walk the ways, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      way_r       <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Load a finished access, drop the result beat once taken
      if (wr_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_ROW) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_command;
            addr_r     <= in_address;
            ways_eff_r <= ways_eff;
            state_r    <= S_PREP;
          end
        end
        S_PREP: begin
          set_r   <= set_c;
          tag_r   <= tag_c;
          state_r <= S_READ;
        end
        S_READ: begin
          way_r   <= '0;
          found_r <= 1'b0;
          free_r  <= 1'b0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (!found_r && cur_match) begin
            found_r     <= 1'b1;
            found_way_r <= way_r;
          end
          if (!free_r && !cur_valid) begin
            free_r     <= 1'b1;
            free_way_r <= way_r;
          end
          if ((way_r == '0) || (cur_rank > vict_rank_r)) begin
            vict_way_r  <= way_r;
            vict_rank_r <= cur_rank;
          end
          if (scan_last) begin
            state_r <= S_WRITE;
          end else begin
            way_r <= way_r + 1'b1;
          end
        end
        S_WRITE: begin
          if (wr_go) begin
            out_hit_r       <= found_r;
            out_mem_write_r <= cmd_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // ---------------------------------------------------------------------------
  // Set memory: one row per set, one read and one write port
  // ---------------------------------------------------------------------------
  row_t              row_mem [MAX_SETS];
  logic              mem_we;
  logic [SET_AW-1:0] mem_waddr;
  row_t              mem_wdata;

  assign mem_we    = (state_r == S_CLEAR) || wr_go;
  assign mem_waddr = (state_r == S_CLEAR) ? clr_cnt_r : set_r;
  assign mem_wdata = (state_r == S_CLEAR) ? row_t'('0) : new_row;

  // Write a cleared row or the updated set
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Register the set read
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      row_rd_r <= row_mem[set_r];
    end
  end

  // ---------------------------------------------------------------------------
  // Running totals
  // ---------------------------------------------------------------------------
  sacts_stats u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt         (evt),
    .hit_total   (out_hit_total),
    .miss_total  (out_miss_total),
    .read_total  (out_read_total),
    .write_total (out_write_total)
  );

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_memory_read  = !out_hit_r;
  assign out_memory_write = out_mem_write_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SACTS_ASSERT_NOW(a_miss_eq_read, clk, rst_n, 1'b1,
                    out_miss_total == out_read_total, "miss and read totals diverged")
  `SACTS_ASSERT_NOW(a_scan_in_range, clk, rst_n, state_r == S_SCAN,
                    WCNT_W'(way_r) < ways_eff_r, "way scan ran past the ways in use")
  `SACTS_ASSERT_NEXT(a_evt_loads_out, clk, rst_n, evt.upd,
                     out_valid_r && (out_hit_r == $past(found_r)),
                     "finished access did not load the result")
  `SACTS_ASSERT_NOW(a_no_accept_busy, clk, rst_n, state_r != S_IDLE, !in_ready,
                    "access accepted while busy")

endmodule

`default_nettype wire
